@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the Hall commutator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold on every clock edge outside reset.
`define HSSC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("hssc assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define HSSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hssc assertion failed");

`endif

@@ rtl/hssc_pkg.sv @@
// ----------------------------------------------------------------------------
// hssc_pkg
// Types, constants and lookup functions of the Hall six-step commutator.
// ----------------------------------------------------------------------------
package hssc_pkg;

    localparam logic [15:0] STOP_WORD  = 16'hC7A0;
    localparam logic [15:0] PAT_MASK   = 16'h333C;
    localparam logic [15:0] PAT_PLUS   = 16'h0028;
    localparam logic [15:0] PAT_MINUS  = 16'h3014;
    localparam logic [15:0] PAT_ZERO   = 16'h0328;
    localparam logic [2:0]  BAD_SECTOR = 3'd7;
    localparam logic [2:0]  LAST_SECTOR = 3'd5;

    // Drive state of one phase
    typedef enum logic [1:0] {
        DRV_PLUS  = 2'd0,
        DRV_MINUS = 2'd1,
        DRV_ZERO  = 2'd2
    } drive_t;

    typedef struct packed {
        logic [15:0] edge_position;
        logic [2:0]  rotor_sector;
        logic        seen_direction;
        logic [15:0] phase_c_word;
        logic [15:0] phase_b_word;
        logic [15:0] phase_a_word;
    } hssc_result_t;

    // Hall code -> sector, BAD_SECTOR for the two impossible codes
    function automatic logic [2:0] sector_map(input logic [2:0] hall);
        logic [2:0] sec;
        case (hall)
            3'd1:    sec = 3'd1;
            3'd2:    sec = 3'd3;
            3'd3:    sec = 3'd2;
            3'd4:    sec = 3'd5;
            3'd5:    sec = 3'd0;
            3'd6:    sec = 3'd4;
            default: sec = BAD_SECTOR;
        endcase
        return sec;
    endfunction

    // Sector plus one, mod 6; an invalid sector also wraps to 0
    function automatic logic [2:0] next_sector(input logic [2:0] s);
        return (s >= LAST_SECTOR) ? 3'd0 : s + 3'd1;
    endfunction

    // (sec + 3*dir) mod 6 for sec in 0..5
    function automatic logic [2:0] step_index(input logic [2:0] sec, input logic dir);
        logic [2:0] idx;
        if (!dir) begin
            idx = sec;
        end else if (sec >= 3'd3) begin
            idx = sec - 3'd3;
        end else begin
            idx = sec + 3'd3;
        end
        return idx;
    endfunction

    // Drive of phases {c, b, a} for a step index
    function automatic logic [5:0] step_drive(input logic [2:0] idx);
        logic [5:0] d;
        case (idx)
            3'd0:    d = {DRV_ZERO,  DRV_MINUS, DRV_PLUS};
            3'd1:    d = {DRV_MINUS, DRV_ZERO,  DRV_PLUS};
            3'd2:    d = {DRV_MINUS, DRV_PLUS,  DRV_ZERO};
            3'd3:    d = {DRV_ZERO,  DRV_PLUS,  DRV_MINUS};
            3'd4:    d = {DRV_PLUS,  DRV_ZERO,  DRV_MINUS};
            3'd5:    d = {DRV_PLUS,  DRV_MINUS, DRV_ZERO};
            default: d = {DRV_ZERO,  DRV_ZERO,  DRV_ZERO};
        endcase
        return d;
    endfunction

    function automatic logic [15:0] drive_bits(input logic [1:0] drv);
        logic [15:0] w;
        case (drv)
            DRV_PLUS:  w = PAT_PLUS;
            DRV_MINUS: w = PAT_MINUS;
            default:   w = PAT_ZERO;
        endcase
        return w;
    endfunction

endpackage

@@ rtl/hssc_core.sv @@
// ----------------------------------------------------------------------------
// hssc_core
// Sector, edge count and PWM word image state; direction and next-value logic.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hssc_core import hssc_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic         cfg_wr_data,
    input  logic         accept,
    input  logic [2:0]   hall_bits,
    input  logic         run_enable,
    input  logic         wanted_direction,
    output hssc_result_t result
);

    logic        hall_invert_reg;
    logic [2:0]  cur_sector_reg, cur_sector_next;
    logic [2:0]  prev_sector_reg, prev_sector_next;
    logic [15:0] edge_count_reg, edge_count_next;
    logic [15:0] image_reg  [3];
    logic [15:0] image_next [3];

    logic [2:0]  hall_eff;
    logic [2:0]  sec;
    logic        dir;
    logic [5:0]  drive;

    always_comb begin
        hall_eff = hall_invert_reg ? ~hall_bits : hall_bits;
        sec      = sector_map(hall_eff);

        if (cur_sector_reg == next_sector(prev_sector_reg)) begin
            dir = 1'b0;
        end else if (next_sector(cur_sector_reg) == prev_sector_reg) begin
            dir = 1'b1;
        end else begin
            dir = wanted_direction;
        end

        drive = step_drive(step_index(sec, wanted_direction));

        for (int p = 0; p < 3; p++) begin
            if (!run_enable) begin
                image_next[p] = STOP_WORD;
            end else if (sec == BAD_SECTOR) begin
                image_next[p] = image_reg[p];
            end else begin
                image_next[p] = (image_reg[p] & ~PAT_MASK) | drive_bits(drive[2*p +: 2]);
            end
        end

        prev_sector_next = cur_sector_reg;
        cur_sector_next  = sec;
        edge_count_next  = dir ? edge_count_reg - 16'd1 : edge_count_reg + 16'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hall_invert_reg <= 1'b0;
            cur_sector_reg  <= 3'd0;
            prev_sector_reg <= 3'd0;
            edge_count_reg  <= 16'd0;
            for (int p = 0; p < 3; p++) begin
                image_reg[p] <= STOP_WORD;
            end
        end else begin
            if (cfg_wr_en) begin
                hall_invert_reg <= cfg_wr_data;
            end
            if (accept) begin
                cur_sector_reg  <= cur_sector_next;
                prev_sector_reg <= prev_sector_next;
                edge_count_reg  <= edge_count_next;
                for (int p = 0; p < 3; p++) begin
                    image_reg[p] <= image_next[p];
                end
            end
        end
    end

    assign result.phase_a_word   = image_next[0];
    assign result.phase_b_word   = image_next[1];
    assign result.phase_c_word   = image_next[2];
    assign result.seen_direction = dir;
    assign result.rotor_sector   = sec;
    assign result.edge_position  = edge_count_next;

    `HSSC_ASSERT_NEXT(a_count_step, aclk, aresetn, accept,
        edge_count_reg == $past(edge_count_reg) + 16'd1 ||
        edge_count_reg == $past(edge_count_reg) - 16'd1)
    `HSSC_ASSERT_NEXT(a_state_hold, aclk, aresetn, !accept,
        $stable(edge_count_reg) && $stable(cur_sector_reg))
    `HSSC_ASSERT_NEXT(a_stop_words, aclk, aresetn, accept && !run_enable,
        image_reg[0] == STOP_WORD && image_reg[1] == STOP_WORD &&
        image_reg[2] == STOP_WORD)

endmodule

@@ rtl/hall_six_step_commutator_top.sv @@
// An accepted request's result is registered in result_reg, which drives m_tdata.
// Throughput: one request per clock while s_tready is high; the output register is refilled in
// the cycle it drains. The single result register sets the rate; after ready_en_reg is set,
// s_tready drops only while that register is full and m_tready is low.
// Reset: synchronous, active low; sectors and edge count clear, all images read 0xC7A0,
// hall_invert clears, and s_tready stays low until the cycle after reset.
// ----------------------------------------------------------------------------
// hall_six_step_commutator_top
// Hall six-step commutator with stream input/output and one config register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hall_six_step_commutator_top import hssc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,     // hall_invert
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,         // [2:0] hall_bits, [3] run_enable,
                                         // [4] wanted_direction, [7:5] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata          // [15:0] phase_a_word, [31:16] phase_b_word,
                                         // [47:32] phase_c_word, [48] seen_direction,
                                         // [51:49] rotor_sector, [67:52] edge_position,
                                         // [71:68] zero
);

    logic         ready_en_reg;
    logic         m_tvalid_reg, m_tvalid_next;
    hssc_result_t result_reg;
    hssc_result_t result;
    logic         accept;

    assign s_tready = ready_en_reg && (!m_tvalid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    hssc_core u_core (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .accept           (accept),
        .hall_bits        (s_tdata[2:0]),
        .run_enable       (s_tdata[3]),
        .wanted_direction (s_tdata[4]),
        .result           (result)
    );

    always_comb begin
        if (accept) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ready_en_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            ready_en_reg <= 1'b1;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            result_reg <= result;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'd0, result_reg};

    `HSSC_ASSERT(a_no_overrun, aclk, aresetn, !(m_tvalid_reg && !m_tready && s_tready))

endmodule

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Stream testbench for the Hall six-step commutator. A scoreboard object
// predicts each event's phase words, judged direction, sector and edge
// position, and checks the results in order. Stimulus is a directed set,
// full-rate spins in both directions, and random rotation with noise,
// under both hall_invert settings and with random gaps on both sides.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import hssc_pkg::*;

    localparam logic DIR_CW  = 1'b0;
    localparam logic DIR_CCW = 1'b1;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic        cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;

    logic        steady_flow;     // no idling on either side while set
    int          stall_request;   // cycles the receiver holds off, taken by receiver
    int          mot_sec;
    logic        mot_ccw;

    class commutation_board;
        logic         invert;
        logic [2:0]   cur_sec;
        logic [2:0]   prev_sec;
        logic [15:0]  images [3];
        logic [15:0]  count;
        logic [2:0]   sector_lut [8];
        drive_t       commutation [6][3];
        hssc_result_t awaited [$];
        int           errors;
        int           checked;
        int           accepted;

        function new();
            invert = 1'b0;
            cur_sec = 3'd0;
            prev_sec = 3'd0;
            foreach (images[p]) images[p] = STOP_WORD;
            count = 16'd0;
            sector_lut = '{BAD_SECTOR, 3'd1, 3'd3, 3'd2, 3'd5, 3'd0, 3'd4, BAD_SECTOR};
            // phases a, b, c per step index
            commutation = '{'{DRV_PLUS,  DRV_MINUS, DRV_ZERO},
                            '{DRV_PLUS,  DRV_ZERO,  DRV_MINUS},
                            '{DRV_ZERO,  DRV_PLUS,  DRV_MINUS},
                            '{DRV_MINUS, DRV_PLUS,  DRV_ZERO},
                            '{DRV_MINUS, DRV_ZERO,  DRV_PLUS},
                            '{DRV_ZERO,  DRV_MINUS, DRV_PLUS}};
            errors = 0;
            checked = 0;
            accepted = 0;
        endfunction

        // sector + 1 mod 6; invalid wraps to 0 too
        function logic [2:0] wrap_up(logic [2:0] s);
            return (s >= LAST_SECTOR) ? 3'd0 : s + 3'd1;
        endfunction

        function logic [15:0] drive_word(drive_t d);
            case (d)
                DRV_PLUS:  return PAT_PLUS;
                DRV_MINUS: return PAT_MINUS;
                default:   return PAT_ZERO;
            endcase
        endfunction

        function void note_event(logic [2:0] code, logic run, logic want);
            logic [2:0]   hall;
            logic [2:0]   sec;
            logic         dir;
            int           step;
            hssc_result_t r;
            hall = invert ? (code ^ 3'b111) : code;
            if (cur_sec == wrap_up(prev_sec)) begin
                dir = DIR_CW;
            end else if (wrap_up(cur_sec) == prev_sec) begin
                dir = DIR_CCW;
            end else begin
                dir = want;
            end
            prev_sec = cur_sec;
            sec = sector_lut[hall];
            cur_sec = sec;
            if (!run) begin
                foreach (images[p]) images[p] = STOP_WORD;
            end else if (sec != BAD_SECTOR) begin
                step = (int'(sec) + 3 * int'(want)) % 6;
                foreach (images[p])
                    images[p] = (images[p] & ~PAT_MASK) | drive_word(commutation[step][p]);
            end
            count = (dir == DIR_CW) ? count + 16'd1 : count - 16'd1;
            r.phase_a_word = images[0];
            r.phase_b_word = images[1];
            r.phase_c_word = images[2];
            r.seen_direction = dir;
            r.rotor_sector = sec;
            r.edge_position = count;
            awaited.push_back(r);
            accepted++;
        endfunction

        function void compare(string field, logic [15:0] exp_v, logic [15:0] got_v);
            if (exp_v !== got_v) begin
                errors++;
                if (errors <= 40)
                    $display("%0t ns: %s expected %h actual %h", $time, field, exp_v, got_v);
            end
        endfunction

        function void check_result(logic [71:0] word);
            hssc_result_t got;
            hssc_result_t exp_r;
            got = hssc_result_t'(word[67:0]);
            checked++;
            if (awaited.size() == 0) begin
                errors++;
                if (errors <= 40)
                    $display("%0t ns: result with nothing awaited, expected none actual %h",
                             $time, word);
                return;
            end
            exp_r = awaited.pop_front();
            compare("phase_a_word", exp_r.phase_a_word, got.phase_a_word);
            compare("phase_b_word", exp_r.phase_b_word, got.phase_b_word);
            compare("phase_c_word", exp_r.phase_c_word, got.phase_c_word);
            compare("seen_direction", 16'(exp_r.seen_direction), 16'(got.seen_direction));
            compare("rotor_sector", 16'(exp_r.rotor_sector), 16'(got.rotor_sector));
            compare("edge_position", exp_r.edge_position, got.edge_position);
        endfunction
    endclass

    commutation_board board = new();

    hall_six_step_commutator_top DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Receiver: random ready, plus a long hold-off when stall_request is set
    initial begin
        int hold;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_request > 0) begin
                hold = stall_request;
                stall_request = 0;
                m_tready <= 1'b0;
                repeat (hold) @(negedge aclk);
            end
            m_tready <= steady_flow ? 1'b1 : ($urandom_range(99) >= 34);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.check_result(m_tdata);
    end

    function automatic logic [2:0] hall_code(int sec);
        logic [2:0] c;
        case (sec)
            0:       c = 3'd5;
            1:       c = 3'd1;
            2:       c = 3'd3;
            3:       c = 3'd2;
            4:       c = 3'd6;
            default: c = 3'd4;
        endcase
        return board.invert ? (c ^ 3'b111) : c;
    endfunction

    // Entered and left at a falling edge
    task automatic send_fields(input logic [2:0] code, input logic run, input logic want);
        int gap;
        gap = 0;
        if (!steady_flow)
            while (gap < 8 && $urandom_range(99) < 34) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {3'b000, want, run, code};
        do @(posedge aclk); while (!s_tready);
        board.note_event(code, run, want);
        @(negedge aclk);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (board.awaited.size() != 0) @(posedge aclk);
        repeat (3) @(negedge aclk);
    endtask

    task automatic write_invert(input logic v);
        settle();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        board.invert = v;
        @(negedge aclk);
    endtask

    // Rotate at full rate through n sectors
    task automatic spin(input int n, input logic ccw);
        int s;
        steady_flow = 1'b1;
        s = (board.cur_sec == BAD_SECTOR) ? 0 : int'(board.cur_sec);
        for (int i = 0; i < n; i++) begin
            s = ccw ? (s + 5) % 6 : (s + 1) % 6;
            send_fields(hall_code(s), 1'b1, ccw);
        end
        steady_flow = 1'b0;
    endtask

    // Mostly clean rotation with reversals, bounces, stops and stray codes
    task automatic run_random(input int n);
        int       r;
        logic [2:0] code;
        logic     run;
        logic     want;
        if (board.cur_sec != BAD_SECTOR) mot_sec = int'(board.cur_sec);
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < 10) mot_ccw = ~mot_ccw;
            if (r < 80) begin
                mot_sec = mot_ccw ? (mot_sec + 5) % 6 : (mot_sec + 1) % 6;
                code = hall_code(mot_sec);
            end else if (r < 90) begin
                code = 3'($urandom_range(7));
            end else begin
                code = hall_code(mot_sec);
            end
            run = ($urandom_range(19) != 0);
            want = ($urandom_range(4) == 0) ? 1'($urandom_range(1)) : mot_ccw;
            send_fields(code, run, want);
        end
    endtask

    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = 8'd0;
        steady_flow = 1'b0;
        stall_request = 0;
        mot_sec = 0;
        mot_ccw = DIR_CW;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Clockwise turn from the reset sectors, wrapping sector 5 to 0
        send_fields(3'd5, 1'b1, DIR_CW);
        send_fields(3'd1, 1'b1, DIR_CW);
        send_fields(3'd3, 1'b1, DIR_CW);
        send_fields(3'd2, 1'b1, DIR_CW);
        send_fields(3'd6, 1'b1, DIR_CW);
        send_fields(3'd4, 1'b1, DIR_CW);
        send_fields(3'd5, 1'b1, DIR_CW);
        // Reverse
        send_fields(3'd4, 1'b1, DIR_CCW);
        send_fields(3'd6, 1'b1, DIR_CCW);
        send_fields(3'd2, 1'b1, DIR_CCW);
        // Invalid codes while running keep the images
        send_fields(3'd7, 1'b1, DIR_CW);
        send_fields(3'd0, 1'b1, DIR_CCW);
        // Out of invalid: stored 7 wraps to 0, so the event after sector 0 judges clockwise
        send_fields(3'd5, 1'b1, DIR_CW);
        send_fields(3'd1, 1'b1, DIR_CCW);
        // Stop, including on an invalid code
        send_fields(3'd3, 1'b0, DIR_CCW);
        send_fields(3'd2, 1'b0, DIR_CW);
        send_fields(3'd7, 1'b0, DIR_CCW);
        send_fields(3'd2, 1'b1, DIR_CCW);

        write_invert(1'b1);
        for (int c = 0; c < 8; c++)
            send_fields(3'(c), 1'b1, 1'($urandom_range(1)));

        // Long receiver hold-off while requests keep coming
        stall_request = 300;
        run_random(150);

        write_invert(1'b0);
        run_random(150);

        // Full-rate spins in both directions
        spin(20, DIR_CW);
        spin(10, DIR_CCW);

        write_invert(1'b1);
        steady_flow = 1'b1;
        run_random(100);
        steady_flow = 1'b0;
        run_random(100);

        write_invert(1'b0);
        run_random(50);

        s_tvalid <= 1'b0;
        while (board.awaited.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);

        $display("Covered %0d Hall events and %0d results under both hall_invert settings:",
                 board.accepted, board.checked);
        $display("both rotations, reversals, invalid codes, stops and a long output stall.");
        if (board.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ hall_six_step_commutator_top.f @@
+incdir+rtl
rtl/hssc_pkg.sv
rtl/hssc_core.sv
rtl/hall_six_step_commutator_top.sv
verif/tb_top.sv
